[rtl/efr_pkg.sv]
// Package for the escaped frame receiver: field widths, register map,
// reset values of the delimiter codes and the shared struct types.
// No dependencies.
package efr_pkg;

    localparam int BYTE_W  = 8;
    localparam int SLOT_W  = 2;
    localparam int INDEX_W = 6;
    localparam int LEN_W   = 7;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam int DEFAULT_SLOTS       = 4;
    localparam int DEFAULT_FRAME_BYTES = 64;

    localparam logic [BYTE_W-1:0] START_CODE_RST  = 8'hC8;
    localparam logic [BYTE_W-1:0] END_CODE_RST    = 8'hC9;
    localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'hCB;
    localparam logic [BYTE_W-1:0] ESC_OR_MASK     = 8'hC0;

    typedef enum logic [1:0] {
        REG_START  = 2'd0,
        REG_END    = 2'd1,
        REG_ESCAPE = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [BYTE_W-1:0] start_code;
        logic [BYTE_W-1:0] end_code;
        logic [BYTE_W-1:0] escape_code;
    } codes_t;

    typedef struct packed {
        logic               valid;
        logic [SLOT_W-1:0]  slot;
        logic [INDEX_W-1:0] byte_index;
        logic [BYTE_W-1:0]  data_byte;
        logic               write_valid;
        logic               frame_done;
        logic [LEN_W-1:0]   frame_length;
    } result_t;

endpackage

[rtl/escaped_frame_receiver.sv]
// Escaped frame receiver top level: register file, input register, deframing core and
// output register. Depends on efr_pkg, efr_apb_regs and efr_deframe_core.
// A result request is offered from the output register once its byte has left the input register.
// Throughput: one byte per cycle unless the output is held; the state update is an unpipelined loop.
// Reset: synchronous, active low; clears the fill index, escape flag and
// slot, empties both registers and restores the default codes.
module escaped_frame_receiver #(
    parameter int SLOTS       = efr_pkg::DEFAULT_SLOTS,
    parameter int FRAME_BYTES = efr_pkg::DEFAULT_FRAME_BYTES
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [efr_pkg::ADDR_W-1:0]  paddr,
    input  logic [efr_pkg::DATA_W-1:0]  pwdata,
    output logic [efr_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [efr_pkg::BYTE_W-1:0]  s_rx_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [efr_pkg::SLOT_W-1:0]  m_slot,
    output logic [efr_pkg::INDEX_W-1:0] m_byte_index,
    output logic [efr_pkg::BYTE_W-1:0]  m_data_byte,
    output logic                        m_write_valid,
    output logic                        m_frame_done,
    output logic [efr_pkg::LEN_W-1:0]   m_frame_length
);

    efr_pkg::codes_t   codes;
    efr_pkg::result_t  res;
    efr_pkg::result_t  out_reg, out_next;
    logic                       in_valid_reg, in_valid_next;
    logic [efr_pkg::BYTE_W-1:0] in_byte_reg;
    logic                       advance;
    logic                       step;
    logic                       in_take;

    efr_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .codes   (codes)
    );

    efr_deframe_core #(
        .SLOTS       (SLOTS),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .rx_byte (in_byte_reg),
        .codes   (codes),
        .res     (res)
    );

    assign advance = !out_reg.valid || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;
    assign in_take = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_next = out_reg;
        if (advance) begin
            out_next       = res;
            out_next.valid = in_valid_reg && res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_reg.valid <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_reg       <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    assign m_valid        = out_reg.valid;
    assign m_slot         = out_reg.slot;
    assign m_byte_index   = out_reg.byte_index;
    assign m_data_byte    = out_reg.data_byte;
    assign m_write_valid  = out_reg.write_valid;
    assign m_frame_done   = out_reg.frame_done;
    assign m_frame_length = out_reg.frame_length;

    // Every request carries either a buffer write or a frame completion.
    a_result_has_meaning: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_write_valid || m_frame_done))
        else $error("result request carries neither write nor frame completion");

    // A length is only reported with a completed frame, and is never zero then.
    a_length_only_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_done ? (m_frame_length != '0) : (m_frame_length == '0)))
        else $error("frame length inconsistent with frame completion");

    // The input side only stalls when both registers are full and the output is held.
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && m_valid && !m_ready))
        else $error("input stalled without a full pipeline");

    // A held byte that is not advanced must still be present in the next cycle.
    a_held_byte_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("stalled input byte was lost");

endmodule

[rtl/efr_apb_regs.sv]
// APB-style register file holding the start, end and escape codes.
// Depends on efr_pkg for the register map and the codes_t struct.
module efr_apb_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [efr_pkg::ADDR_W-1:0] paddr,
    input  logic [efr_pkg::DATA_W-1:0] pwdata,
    output logic [efr_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output efr_pkg::codes_t            codes
);

    efr_pkg::codes_t codes_reg;
    efr_pkg::codes_t codes_next;
    efr_pkg::reg_idx_t reg_idx;
    logic wr_en;

    assign reg_idx = efr_pkg::reg_idx_t'(paddr[efr_pkg::ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign codes   = codes_reg;

    always_comb begin
        codes_next = codes_reg;
        if (wr_en) begin
            case (reg_idx)
                efr_pkg::REG_START:  codes_next.start_code  = pwdata[efr_pkg::BYTE_W-1:0];
                efr_pkg::REG_END:    codes_next.end_code    = pwdata[efr_pkg::BYTE_W-1:0];
                efr_pkg::REG_ESCAPE: codes_next.escape_code = pwdata[efr_pkg::BYTE_W-1:0];
                default: codes_next = codes_reg;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            efr_pkg::REG_START:  prdata[efr_pkg::BYTE_W-1:0] = codes_reg.start_code;
            efr_pkg::REG_END:    prdata[efr_pkg::BYTE_W-1:0] = codes_reg.end_code;
            efr_pkg::REG_ESCAPE: prdata[efr_pkg::BYTE_W-1:0] = codes_reg.escape_code;
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            codes_reg.start_code  <= efr_pkg::START_CODE_RST;
            codes_reg.end_code    <= efr_pkg::END_CODE_RST;
            codes_reg.escape_code <= efr_pkg::ESCAPE_CODE_RST;
        end else begin
            codes_reg <= codes_next;
        end
    end

endmodule

[rtl/efr_deframe_core.sv]
// Deframing state (fill index, escape flag, current slot) and the decode
// of one received byte into a buffer write, a frame completion, both or neither.
// Depends on efr_pkg for the field widths and the result_t struct.
module efr_deframe_core #(
    parameter int SLOTS       = efr_pkg::DEFAULT_SLOTS,
    parameter int FRAME_BYTES = efr_pkg::DEFAULT_FRAME_BYTES
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic [efr_pkg::BYTE_W-1:0] rx_byte,
    input  efr_pkg::codes_t            codes,
    output efr_pkg::result_t           res
);

    localparam int FILL_W = $clog2(FRAME_BYTES + 1);
    localparam int SCNT_W = $clog2(SLOTS);

    logic [FILL_W-1:0] fill_index_reg, fill_index_next;
    logic              escape_pending_reg, escape_pending_next;
    logic [SCNT_W-1:0] current_slot_reg, current_slot_next;

    logic              room_for_end;
    logic              buffer_full;
    logic [FILL_W-1:0] fill_inc;
    logic [FILL_W-1:0] len_raw;
    logic [FILL_W-1:0] len_sat;
    logic [31:0]       fill_wide;
    logic [31:0]       len_wide;
    logic [31:0]       slot_wide;

    assign room_for_end = fill_index_reg < FILL_W'(FRAME_BYTES);
    assign buffer_full  = fill_index_reg >= FILL_W'(FRAME_BYTES - 1);
    assign fill_inc     = fill_index_reg + FILL_W'(1);
    assign len_raw      = room_for_end ? fill_inc : fill_index_reg;
    assign len_sat      = (len_raw > FILL_W'(FRAME_BYTES)) ? FILL_W'(FRAME_BYTES) : len_raw;
    assign fill_wide    = {{(32-FILL_W){1'b0}}, fill_index_reg};
    assign len_wide     = {{(32-FILL_W){1'b0}}, len_sat};
    assign slot_wide    = {{(32-SCNT_W){1'b0}}, current_slot_reg};

    always_comb begin
        fill_index_next     = fill_index_reg;
        escape_pending_next = escape_pending_reg;
        current_slot_next   = current_slot_reg;
        res                 = '0;
        res.slot            = slot_wide[efr_pkg::SLOT_W-1:0];
        if (rx_byte == codes.start_code) begin
            escape_pending_next = 1'b0;
            fill_index_next     = FILL_W'(1);
            res.valid           = 1'b1;
            res.data_byte       = rx_byte;
            res.write_valid     = 1'b1;
        end else if (rx_byte == codes.end_code) begin
            res.valid        = 1'b1;
            res.frame_done   = 1'b1;
            res.frame_length = len_wide[efr_pkg::LEN_W-1:0];
            if (room_for_end) begin
                res.byte_index  = fill_wide[efr_pkg::INDEX_W-1:0];
                res.data_byte   = rx_byte;
                res.write_valid = 1'b1;
                fill_index_next = fill_inc;
            end
            if (current_slot_reg == SCNT_W'(SLOTS - 1)) begin
                current_slot_next = '0;
            end else begin
                current_slot_next = current_slot_reg + SCNT_W'(1);
            end
        end else if (!buffer_full) begin
            if (rx_byte == codes.escape_code) begin
                escape_pending_next = 1'b1;
            end else begin
                res.valid           = 1'b1;
                res.byte_index      = fill_wide[efr_pkg::INDEX_W-1:0];
                res.data_byte       = escape_pending_reg ? (rx_byte | efr_pkg::ESC_OR_MASK)
                                                         : rx_byte;
                res.write_valid     = 1'b1;
                escape_pending_next = 1'b0;
                fill_index_next     = fill_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_index_reg     <= '0;
            escape_pending_reg <= 1'b0;
            current_slot_reg   <= '0;
        end else if (step) begin
            fill_index_reg     <= fill_index_next;
            escape_pending_reg <= escape_pending_next;
            current_slot_reg   <= current_slot_next;
        end
    end

endmodule
